// File: rtl/core/sem_pkg.sv
// shared types and constants for the sobel edge magnitude block
// no dependencies
`default_nettype none
package sem_pkg;
   localparam int MaxLine  = 1024;
   localparam int AddrBits = $clog2(MaxLine);
   localparam int MaxRows  = 4096;
   localparam int RowBits  = $clog2(MaxRows);
   localparam int PixBits  = 24;
   localparam int RootSteps = 11;

   typedef logic [8:0][7:0] taps_type;

   typedef struct packed {
      logic                rd_en;
      logic                wr_en;
      logic [AddrBits-1:0] addr;
   } line_ctl_type;

   localparam logic [0:0] RegLineWidth   = 1'b0;
   localparam logic [0:0] RegFrameHeight = 1'b1;
endpackage
`default_nettype wire

// File: rtl/core/sem_line_store.sv
// two line stores of one row of pixels each, registered read
// depends on sem_pkg
`default_nettype none
module sem_line_store
   import sem_pkg::*;
(
   input  wire logic               clock,
   input  wire line_ctl_type       ctl,
   input  wire logic [PixBits-1:0] pix,
   output logic      [PixBits-1:0] upper_rd,
   output logic      [PixBits-1:0] middle_rd
);
   logic [PixBits-1:0] upper_mem [MaxLine];
   logic [PixBits-1:0] middle_mem [MaxLine];

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         upper_rd  <= upper_mem[ctl.addr];
         middle_rd <= middle_mem[ctl.addr];
      end
      if (ctl.wr_en) begin
         upper_mem[ctl.addr]  <= middle_rd;
         middle_mem[ctl.addr] <= pix;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/sem_lane.sv
// one color channel: sobel gradients, squared sum, iterative square root, rounding
// depends on sem_pkg
`default_nettype none
module sem_lane
   import sem_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire taps_type taps,
   output logic          done,
   output logic [7:0]    mag
);
   typedef enum logic [1:0] {L_IDLE, L_SQ, L_ROOT, L_FIN} lstate_type;

   lstate_type  state_ff;
   logic [9:0]  ax_ff, ay_ff;
   logic [21:0] s_ff;
   logic [10:0] root_ff;
   logic [13:0] rem_ff;
   logic [3:0]  cnt_ff;
   logic        done_ff;
   logic [7:0]  mag_ff;

   logic signed [11:0] gx, gy;
   logic [9:0]  ax_in, ay_in;
   logic [13:0] rem_sh, trial;
   logic [11:0] q_round;

   always_comb begin
      gx = 12'(signed'({4'd0, taps[2]})) + 12'(signed'({3'd0, taps[5], 1'b0}))
         + 12'(signed'({4'd0, taps[8]})) - 12'(signed'({4'd0, taps[0]}))
         - 12'(signed'({3'd0, taps[3], 1'b0})) - 12'(signed'({4'd0, taps[6]}));
      gy = 12'(signed'({4'd0, taps[6]})) + 12'(signed'({3'd0, taps[7], 1'b0}))
         + 12'(signed'({4'd0, taps[8]})) - 12'(signed'({4'd0, taps[0]}))
         - 12'(signed'({3'd0, taps[1], 1'b0})) - 12'(signed'({4'd0, taps[2]}));
      ax_in = gx[11] ? 10'(-gx) : gx[9:0];
      ay_in = gy[11] ? 10'(-gy) : gy[9:0];
      rem_sh = {rem_ff[11:0], s_ff[21:20]};
      trial  = {1'b0, root_ff, 2'b01};
      q_round = {1'b0, root_ff} + {11'd0, (rem_ff > {3'd0, root_ff})};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            L_IDLE: begin
               if (start) begin
                  ax_ff    <= ax_in;
                  ay_ff    <= ay_in;
                  state_ff <= L_SQ;
               end
            end
            L_SQ: begin
               s_ff     <= {1'b0, 21'(ax_ff) * 21'(ax_ff) + 21'(ay_ff) * 21'(ay_ff)};
               root_ff  <= '0;
               rem_ff   <= '0;
               cnt_ff   <= 4'(RootSteps - 1);
               state_ff <= L_ROOT;
            end
            L_ROOT: begin
               s_ff <= {s_ff[19:0], 2'b00};
               if (rem_sh >= trial) begin
                  rem_ff  <= rem_sh - trial;
                  root_ff <= {root_ff[9:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[9:0], 1'b0};
               end
               if (cnt_ff == 4'd0) state_ff <= L_FIN;
               else cnt_ff <= cnt_ff - 4'd1;
            end
            L_FIN: begin
               mag_ff   <= (root_ff >= 11'd255) ? 8'd255 : q_round[7:0];
               done_ff  <= 1'b1;
               state_ff <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign mag  = mag_ff;
endmodule
`default_nettype wire

// File: rtl/core/sem_merge.sv
// output register that joins the three lane magnitudes into one response
// depends on sem_pkg
`default_nettype none
module sem_merge
   import sem_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire logic [7:0]  red_mag,
   input  wire logic [7:0]  green_mag,
   input  wire logic [7:0]  blue_mag,
   input  wire logic        last,
   input  wire logic        frame_done,
   output logic             free,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast,
   output logic [0:0]       rsp_tuser
);
   logic        valid_ff;
   logic [23:0] data_ff;
   logic        last_ff, fd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         data_ff <= {blue_mag, green_mag, red_mag};
         last_ff <= last;
         fd_ff   <= frame_done;
      end
   end

   assign free       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = fd_ff;
endmodule
`default_nettype wire

// File: rtl/core/sobel_edge_magnitude_3x3_top.sv
// top level: pixel counters, line stores, 3x3 window, three channel lanes, output merge
// depends on sem_pkg, sem_line_store, sem_lane, sem_merge
`default_nettype none
// Streams RGB pixels in raster order and returns the rounded Sobel gradient magnitude of
// each channel, clamped to 255, with neighbors outside the frame taken as zero. An
// accepted pixel yields zero to four responses (more at the right column and bottom row);
// tlast marks the last response of a request and tuser marks the frame's final pixel.
// A request reads and writes the line stores, then visits each of the four possible response
// slots in turn; for each response produced the three channel lanes run in parallel, each
// with its own iterative square root (gradient, squaring, eleven square root steps,
// rounding), and the result then waits for the output register to be free. No new pixel
// is accepted until all responses of the current one have been handed to the output.
// Configuration writes restart the frame.
module sobel_edge_magnitude_3x3_top
   import sem_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red_in, green_in, blue_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // red_edge, green_edge, blue_edge
   output logic             rsp_tlast,   // last_of_run
   output logic [0:0]       rsp_tuser,   // frame_done
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   typedef enum logic [2:0] {S_IDLE, S_LOAD, S_PICK, S_WAIT, S_OUT} state_type;

   state_type           state_ff;
   logic [10:0]         lw_ff;
   logic [12:0]         fh_ff;
   logic [AddrBits-1:0] col_ff, cur_c_ff;
   logic [RowBits-1:0]  row_ff, cur_r_ff;
   logic [PixBits-1:0]  px_ff;
   logic [1:0]          idx_ff;
   logic [3:0]          vm_ff;
   logic [2:0][2:0][PixBits-1:0] win_ff;

   logic [10:0]         w_eff;
   logic [12:0]         h_eff;
   logic [AddrBits-1:0] w_m1;
   logic [RowBits-1:0]  h_m1;
   logic                req_acc, cfg_wr;
   line_ctl_type        lctl;
   logic [PixBits-1:0]  up_rd, mid_rd;
   logic [RowBits-1:0]  out_i;
   logic [AddrBits-1:0] out_j;
   logic [2:0]          row_ok, col_ok;
   logic [2:0][8:0][7:0] lane_taps;
   logic [2:0]          lane_done;
   logic [2:0][7:0]     lane_mag;
   logic                lane_start, merge_free, merge_load, res_last, res_fd;
   logic [3:0]          vm_in, above;
   logic [2:0]          wr, wc;

   assign w_eff = (lw_ff == 11'd0) ? 11'd1 : (lw_ff > 11'(MaxLine)) ? 11'(MaxLine) : lw_ff;
   assign h_eff = (fh_ff == 13'd0) ? 13'd1 : (fh_ff > 13'(MaxRows)) ? 13'(MaxRows) : fh_ff;
   assign w_m1  = AddrBits'(w_eff - 11'd1);
   assign h_m1  = RowBits'(h_eff - 13'd1);

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2:2])
         RegLineWidth:   csr_prdata = {21'd0, lw_ff};
         RegFrameHeight: csr_prdata = {19'd0, fh_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign lctl.rd_en = req_acc;
   assign lctl.wr_en = (state_ff == S_LOAD);
   assign lctl.addr  = (state_ff == S_IDLE) ? col_ff : cur_c_ff;

   sem_line_store u_lines (
      .clock     (clock),
      .ctl       (lctl),
      .pix       (px_ff),
      .upper_rd  (up_rd),
      .middle_rd (mid_rd)
   );

   always_comb begin
      vm_in[0] = (cur_r_ff != '0) && (cur_c_ff != '0);
      vm_in[1] = (cur_r_ff != '0) && (cur_c_ff == w_m1);
      vm_in[2] = (cur_r_ff == h_m1) && (cur_c_ff != '0);
      vm_in[3] = (cur_r_ff == h_m1) && (cur_c_ff == w_m1);
      out_i  = idx_ff[1] ? cur_r_ff : cur_r_ff - RowBits'(1);
      out_j  = idx_ff[0] ? cur_c_ff : cur_c_ff - AddrBits'(1);
      row_ok = {out_i != h_m1, 1'b1, out_i != '0};
      col_ok = {out_j != w_m1, 1'b1, out_j != '0};
      above  = 4'(4'b1110 << idx_ff);
      res_last = (vm_ff & above) == 4'd0;
      res_fd   = (out_i == h_m1) && (out_j == w_m1);
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 3; k++) begin
            for (int l = 0; l < 3; l++) begin
               wr = 3'(k) + {2'd0, idx_ff[1]};
               wc = 3'(l) + {2'd0, idx_ff[0]};
               if (row_ok[k] && col_ok[l] && wr != 3'd3 && wc != 3'd3)
                  lane_taps[ch][k*3+l] = win_ff[wr[1:0]][wc[1:0]][ch*8 +: 8];
               else
                  lane_taps[ch][k*3+l] = 8'd0;
            end
         end
      end
   end

   assign lane_start = (state_ff == S_PICK) && vm_ff[idx_ff];

   for (genvar g = 0; g < 3; g++) begin : g_lane
      sem_lane u_lane (
         .clock (clock),
         .reset (reset),
         .start (lane_start),
         .taps  (lane_taps[g]),
         .done  (lane_done[g]),
         .mag   (lane_mag[g])
      );
   end

   assign merge_load = (state_ff == S_OUT) && merge_free;

   sem_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (merge_load),
      .red_mag    (lane_mag[0]),
      .green_mag  (lane_mag[1]),
      .blue_mag   (lane_mag[2]),
      .last       (res_last),
      .frame_done (res_fd),
      .free       (merge_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lw_ff    <= 11'd1024;
         fh_ff    <= 13'd768;
         col_ff   <= '0;
         row_ff   <= '0;
         idx_ff   <= '0;
         vm_ff    <= '0;
         win_ff   <= '0;
      end else begin
         if (cfg_wr) begin
            unique case (csr_paddr[2:2])
               RegLineWidth:   lw_ff <= csr_pwdata[10:0];
               RegFrameHeight: fh_ff <= csr_pwdata[12:0];
               default: ;
            endcase
            col_ff <= '0;
            row_ff <= '0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  px_ff    <= {req_tdata[23:16], req_tdata[15:8], req_tdata[7:0]};
                  cur_c_ff <= col_ff;
                  cur_r_ff <= row_ff;
                  if (col_ff == w_m1) begin
                     col_ff <= '0;
                     row_ff <= (row_ff == h_m1) ? '0 : row_ff + RowBits'(1);
                  end else begin
                     col_ff <= col_ff + AddrBits'(1);
                  end
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               for (int k = 0; k < 3; k++) begin
                  win_ff[k][0] <= win_ff[k][1];
                  win_ff[k][1] <= win_ff[k][2];
               end
               win_ff[0][2] <= up_rd;
               win_ff[1][2] <= mid_rd;
               win_ff[2][2] <= px_ff;
               vm_ff    <= vm_in;
               idx_ff   <= '0;
               state_ff <= S_PICK;
            end
            S_PICK: begin
               if (vm_ff[idx_ff]) state_ff <= S_WAIT;
               else if (idx_ff == 2'd3) state_ff <= S_IDLE;
               else idx_ff <= idx_ff + 2'd1;
            end
            S_WAIT: begin
               if (lane_done[0]) state_ff <= S_OUT;
            end
            S_OUT: begin
               if (merge_free) begin
                  if (idx_ff == 2'd3) state_ff <= S_IDLE;
                  else begin
                     idx_ff   <= idx_ff + 2'd1;
                     state_ff <= S_PICK;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_fd_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast)
      else $error("frame end response without last marker");
   a_lane_sync: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> (state_ff == S_WAIT && lane_done[1] && lane_done[2]))
      else $error("lane finished outside wait or lanes out of step");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < w_eff) && ({1'b0, row_ff} < h_eff))
      else $error("pixel counter beyond frame");
endmodule
`default_nettype wire

// File: test/tb_sobel_edge_magnitude_3x3_top.sv
// testbench for sobel_edge_magnitude_3x3_top: drives pixel frames, predicts the edge magnitudes
// and checks every response; depends on sem_pkg and the top level
`timescale 1ns / 1ps
module tb_sobel_edge_magnitude_3x3_top;
   import sem_pkg::*;

   localparam int DrainCycles = 120;
   localparam int StallLimit  = 20000;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
      logic       done;
   } edge_pix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sobel_edge_magnitude_3x3_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [23:0]  upper_row [MaxLine];
   logic [23:0]  middle_row [MaxLine];
   logic [23:0]  win [3][3];
   int unsigned  col_pos = 0;
   int unsigned  row_pos = 0;
   logic [10:0]  width_reg = 11'd1024;
   logic [12:0]  height_reg = 13'd768;

   edge_pix_type mag_q[$];
   int           errors = 0;
   int           pixels_sent = 0;
   int           send_idle = 0;
   int           recv_idle = 0;
   int           quiet_cycles = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MaxLine) return MaxLine;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MaxRows) return MaxRows;
      return height_reg;
   endfunction

   function automatic logic [7:0] round_root(input int gx, input int gy);
      int unsigned s;
      int unsigned q;
      s = gx * gx + gy * gy;
      q = 0;
      for (int b = 15; b >= 0; b--) begin
         if ((q | (1 << b)) * (q | (1 << b)) <= s) q = q | (1 << b);
      end
      if (s > q * q + q) q++;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic edge_pix_type sobel_at(input int i, input int j, input int r, input int c,
                                             input int w, input int h);
      int kx [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
      int ky [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
      int gx [3] = '{0, 0, 0};
      int gy [3] = '{0, 0, 0};
      int ni, nj, wr, wc, v;
      edge_pix_type res;
      for (int k = -1; k <= 1; k++) begin
         for (int l = -1; l <= 1; l++) begin
            ni = i + k;
            nj = j + l;
            wr = ni - r + 2;
            wc = nj - c + 2;
            if (ni >= 0 && ni < h && nj >= 0 && nj < w && wr >= 0 && wr <= 2
                && wc >= 0 && wc <= 2) begin
               // red sits in the lowest byte of the request
               for (int ch = 0; ch < 3; ch++) begin
                  v = (win[wr][wc] >> (8 * ch)) & 8'hff;
                  gx[ch] += v * kx[k + 1][l + 1];
                  gy[ch] += v * ky[k + 1][l + 1];
               end
            end
         end
      end
      res.red   = round_root(gx[0], gy[0]);
      res.green = round_root(gx[1], gy[1]);
      res.blue  = round_root(gx[2], gy[2]);
      res.last  = 1'b0;
      res.done  = (i == h - 1 && j == w - 1);
      return res;
   endfunction

   task automatic predict_pixel(input logic [23:0] px);
      int unsigned w, h, c, r;
      int rows [$];
      int cols [$];
      int first;
      logic [23:0] up, mid;
      w = eff_width();
      h = eff_height();
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      up = upper_row[c];
      mid = middle_row[c];
      upper_row[c] = mid;
      middle_row[c] = px;
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = px;
      if (r >= 1) rows.push_back(r - 1);
      if (r == h - 1) rows.push_back(r);
      if (c >= 1) cols.push_back(c - 1);
      if (c == w - 1) cols.push_back(c);
      first = mag_q.size();
      foreach (rows[a]) begin
         foreach (cols[b]) mag_q.push_back(sobel_at(rows[a], cols[b], r, c, w, h));
      end
      if (mag_q.size() > first) mag_q[mag_q.size() - 1].last = 1'b1;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   // one request; entered just after a rising edge, returns just after its acceptance
   task automatic send_pixel(input logic [23:0] px);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      predict_pixel(px);
      pixels_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (mag_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_access(input logic [0:0] idx, input logic wr, input logic [31:0] value,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(input logic [31:0] wval, input logic [31:0] hval);
      logic [31:0] rd;
      csr_access(RegLineWidth, 1'b1, wval, rd);
      width_reg = wval[10:0];
      col_pos = 0;
      row_pos = 0;
      csr_access(RegFrameHeight, 1'b1, hval, rd);
      height_reg = hval[12:0];
      col_pos = 0;
      row_pos = 0;
      csr_access(RegLineWidth, 1'b0, '0, rd);
      if (rd[10:0] != width_reg) report_mismatch("line_width readback", rd[10:0], width_reg);
      csr_access(RegFrameHeight, 1'b0, '0, rd);
      if (rd[12:0] != height_reg) report_mismatch("frame_height readback", rd[12:0], height_reg);
   endtask

   function automatic logic [23:0] pick_pixel(input int mode);
      case (mode)
         0: return {$urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00,
                    $urandom_range(1) ? 8'hff : 8'h00};
         1: return 24'h1 << $urandom_range(23);
         default: return $urandom();
      endcase
   endfunction

   task automatic run_frame(input int unsigned w, input int unsigned h, input int count);
      int mode;
      mode = $urandom_range(3);
      set_frame($urandom() & ~32'h7ff | w, $urandom() & ~32'h1fff | h);
      for (int n = 0; n < count; n++) send_pixel(pick_pixel(mode));
      drain_results();
   endtask

   task automatic test_register_reset();
      logic [31:0] rd;
      csr_access(RegLineWidth, 1'b0, '0, rd);
      if (rd[10:0] != 11'd1024) report_mismatch("line_width reset", rd[10:0], 1024);
      csr_access(RegFrameHeight, 1'b0, '0, rd);
      if (rd[12:0] != 13'd768) report_mismatch("frame_height reset", rd[12:0], 768);
   endtask

   task automatic test_directed();
      logic [23:0] pat [12] = '{24'hffffff, 24'h000000, 24'hffffff, 24'h000000,
                                24'h000000, 24'hffffff, 24'h000000, 24'hffffff,
                                24'hff00ff, 24'h00ff00, 24'h0000ff, 24'h808080};
      set_frame(32'd4, 32'd3);
      foreach (pat[k]) send_pixel(pat[k]);
      drain_results();
      // single pixel frame, then out of range sizes acting as 1
      set_frame(32'd1, 32'd1);
      send_pixel(24'hffffff);
      send_pixel(24'h123456);
      drain_results();
      set_frame(32'd0, 32'd0);
      send_pixel(24'hffffff);
      send_pixel(24'h00ff00);
      drain_results();
      // widest line, tallest frame
      set_frame(32'd1024, 32'd4096);
      repeat (4) send_pixel(24'hffffff);
      drain_results();
      set_frame(32'd2047, 32'd8191);
      repeat (3) send_pixel(24'h00ffff);
      drain_results();
   endtask

   task automatic test_large_sizes();
      run_frame(1024, 2, 40);
      run_frame(1, 4096, 30);
      run_frame(2047, 1, 20);
      run_frame(3, 8191, 12);
   endtask

   task automatic test_random_frames(input int sidle, input int ridle, input int quota);
      int unsigned w, h;
      int target;
      send_idle = sidle;
      recv_idle = ridle;
      target = pixels_sent + quota;
      while (pixels_sent < target) begin
         w = $urandom_range(7, 1);
         h = $urandom_range(6, 1);
         // sometimes stop early, sometimes run into the next frame
         run_frame(w, h, $urandom_range(3) == 0 ? $urandom_range(w * h + w, 1) : w * h);
      end
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      edge_pix_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (mag_q.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = mag_q.pop_front();
            if (rsp_tdata[7:0] != want.red) report_mismatch("red_edge", rsp_tdata[7:0], want.red);
            if (rsp_tdata[15:8] != want.green)
               report_mismatch("green_edge", rsp_tdata[15:8], want.green);
            if (rsp_tdata[23:16] != want.blue)
               report_mismatch("blue_edge", rsp_tdata[23:16], want.blue);
            if (rsp_tlast != want.last) report_mismatch("last_of_run", rsp_tlast, want.last);
            if (rsp_tuser[0] != want.done) report_mismatch("frame_done", rsp_tuser, want.done);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_reset();
      test_directed();
      test_random_frames(7, 59, 75);
      test_large_sizes();
      test_random_frames(59, 7, 65);
      test_random_frames(0, 0, 85);
      drain_results();
      if (errors == 0 && mag_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/core/sem_pkg.sv
rtl/core/sem_line_store.sv
rtl/core/sem_lane.sv
rtl/core/sem_merge.sv
rtl/core/sobel_edge_magnitude_3x3_top.sv
test/tb_sobel_edge_magnitude_3x3_top.sv
